@@ hw/rtl/lsfe_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsfe_pkg - shared types and constants of the LED strip frame encoder
// Command codes, queued operation type, register map and register resets.
// ----------------------------------------------------------------------------
package lsfe_pkg;

	localparam logic [1:0] CMD_LIGHT_ONE = 2'd0;
	localparam logic [1:0] CMD_LIGHT_ALL = 2'd1;
	localparam logic [1:0] CMD_NEXT      = 2'd2;

	localparam logic [2:0] REG_ZERO_HIGH  = 3'd0;
	localparam logic [2:0] REG_ZERO_LOW   = 3'd1;
	localparam logic [2:0] REG_ONE_HIGH   = 3'd2;
	localparam logic [2:0] REG_ONE_LOW    = 3'd3;
	localparam logic [2:0] REG_LATCH_HALF = 3'd4;

	localparam logic [7:0]  RST_ZERO_HIGH  = 8'd3;
	localparam logic [7:0]  RST_ZERO_LOW   = 8'd9;
	localparam logic [7:0]  RST_ONE_HIGH   = 8'd9;
	localparam logic [7:0]  RST_ONE_LOW    = 8'd3;
	localparam logic [15:0] RST_LATCH_HALF = 16'd250;

	typedef enum logic [1:0] {
		OP_LIGHT_ONE,
		OP_LIGHT_ALL,
		OP_NEXT
	} op_t;

	// One classified item on its way from the front to the back.
	typedef struct packed {
		op_t         op;
		logic        hit;     // key lies on the strip
		logic [7:0]  key;
		logic [23:0] colour;  // red 23..16, green 15..8, blue 7..0
	} entry_t;

	typedef struct packed {
		logic        we;
		logic [2:0]  index;
		logic [15:0] data;
	} cfg_wr_t;

endpackage
`default_nettype wire

@@ hw/rtl/lsfe_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsfe_front - input decode
// Accepts items, drops unused command codes, checks the key against the
// strip length and hands the classified item to the queue.
// ----------------------------------------------------------------------------
module lsfe_front import lsfe_pkg::*; #(
	parameter int LED_COUNT = 16
) (
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // key_index, red, green, blue
	input  wire logic [1:0]  s_tuser,   // command
	input  wire logic        q_ready,
	output logic             push,
	output entry_t           entry
);

	localparam logic [7:0] LED_COUNT_B = 8'(LED_COUNT);

	logic known;

	assign s_tready = q_ready;

	always_comb begin
		entry.key    = s_tdata[7:0];
		entry.colour = {s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};
		entry.hit    = (s_tdata[7:0] < LED_COUNT_B);
		entry.op     = OP_NEXT;
		known        = 1'b1;
		unique case (s_tuser)
			CMD_LIGHT_ONE: entry.op = OP_LIGHT_ONE;
			CMD_LIGHT_ALL: entry.op = OP_LIGHT_ALL;
			CMD_NEXT:      entry.op = OP_NEXT;
			default:       known = 1'b0;
		endcase
	end

	// drop unused codes at the door
	assign push = s_tvalid && q_ready && known;

endmodule
`default_nettype wire

@@ hw/rtl/lsfe_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsfe_queue - two-entry queue between front and back
// Lets the front keep accepting while the back waits on the output.
// ----------------------------------------------------------------------------
module lsfe_queue import lsfe_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t wr_entry,
	output logic        ready,
	input  wire logic   pop,
	output logic        valid,
	output entry_t      rd_entry
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

	entry_t           slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign ready    = (count_q != FULL);
	assign valid    = (count_q != '0);
	assign rd_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/lsfe_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsfe_back - frame state and symbol generation
// Holds the frame description, timing registers and cursors; executes one
// queued item per cycle unless the output stalls; drives the output register.
// ----------------------------------------------------------------------------
module lsfe_back import lsfe_pkg::*; #(
	parameter int LED_COUNT = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_wr_t     cfg,
	input  wire logic        q_valid,
	input  wire entry_t      q_entry,
	output logic             pop,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // first_level, first_ticks, second_ticks
	output logic             m_tlast    // frame_end
);

	localparam int PIX_W = $clog2(LED_COUNT + 1);
	localparam logic [PIX_W-1:0] PIX_END = PIX_W'(LED_COUNT);

	// The store is always written whole: all pixels one colour, or at most one
	// pixel lit and the rest dark. Keep only that description.
	logic        all_q;
	logic        hit_q;
	logic [7:0]  key_q;
	logic [23:0] colour_q;

	logic [PIX_W-1:0] pix_q;
	logic [1:0]       byte_q;
	logic [2:0]       bit_q;
	logic             armed_q;

	logic [7:0]  zero_high_q;
	logic [7:0]  zero_low_q;
	logic [7:0]  one_high_q;
	logic [7:0]  one_low_q;
	logic [15:0] latch_half_q;

	logic        out_valid_q;
	logic        level_q;
	logic [15:0] first_q;
	logic [15:0] second_q;
	logic        end_q;

	logic        out_free;
	logic        emit;
	logic        latch;
	logic [23:0] pix_colour;
	logic [7:0]  cur_byte;
	logic        cur_bit;

	assign out_free = !out_valid_q || m_tready;
	assign emit     = q_valid && (q_entry.op == OP_NEXT) && armed_q;
	assign pop      = q_valid && (!emit || out_free);
	assign latch    = (pix_q == PIX_END);

	always_comb begin
		pix_colour = (all_q || (hit_q && key_q == 8'(pix_q))) ? colour_q : '0;
		unique case (byte_q)
			2'd0:    cur_byte = pix_colour[23:16];
			2'd1:    cur_byte = pix_colour[15:8];
			2'd2:    cur_byte = pix_colour[7:0];
			default: cur_byte = 8'h00;
		endcase
		cur_bit = cur_byte[~bit_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_high_q  <= RST_ZERO_HIGH;
			zero_low_q   <= RST_ZERO_LOW;
			one_high_q   <= RST_ONE_HIGH;
			one_low_q    <= RST_ONE_LOW;
			latch_half_q <= RST_LATCH_HALF;
		end else if (cfg.we) begin
			unique case (cfg.index)
				REG_ZERO_HIGH:  zero_high_q  <= cfg.data[7:0];
				REG_ZERO_LOW:   zero_low_q   <= cfg.data[7:0];
				REG_ONE_HIGH:   one_high_q   <= cfg.data[7:0];
				REG_ONE_LOW:    one_low_q    <= cfg.data[7:0];
				REG_LATCH_HALF: latch_half_q <= cfg.data;
				default:        ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop && q_entry.op != OP_NEXT) begin
			key_q    <= q_entry.key;
			colour_q <= q_entry.colour;
		end
		if (pop && emit) begin
			if (latch) begin
				level_q  <= 1'b0;
				first_q  <= latch_half_q;
				second_q <= latch_half_q;
				end_q    <= 1'b1;
			end else begin
				level_q  <= 1'b1;
				first_q  <= {8'h00, cur_bit ? one_high_q : zero_high_q};
				second_q <= {8'h00, cur_bit ? one_low_q : zero_low_q};
				end_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			all_q       <= 1'b0;
			hit_q       <= 1'b0;
			pix_q       <= '0;
			byte_q      <= '0;
			bit_q       <= '0;
			armed_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				unique case (q_entry.op)
					OP_LIGHT_ONE, OP_LIGHT_ALL: begin
						all_q   <= (q_entry.op == OP_LIGHT_ALL);
						hit_q   <= q_entry.hit;
						pix_q   <= '0;
						byte_q  <= '0;
						bit_q   <= '0;
						armed_q <= 1'b1;
					end
					default: begin
						if (emit) begin
							if (latch) begin
								pix_q   <= '0;
								byte_q  <= '0;
								bit_q   <= '0;
								armed_q <= 1'b0;
							end else begin
								bit_q <= bit_q + 1'b1;
								if (bit_q == 3'd7) begin
									if (byte_q == 2'd2) begin
										byte_q <= '0;
										pix_q  <= pix_q + 1'b1;
									end else begin
										byte_q <= byte_q + 1'b1;
									end
								end
							end
						end
					end
				endcase
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, second_q, first_q, level_q};
	assign m_tlast  = end_q;

endmodule
`default_nettype wire

@@ hw/rtl/led_strip_frame_encoder_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// led_strip_frame_encoder_core - pulse symbol source for an LED strip
// Front decode, two-entry queue, and frame/symbol back end.
// ----------------------------------------------------------------------------
// Takes one item per clock while the queue has room. A light command redraws
// the frame and rearms it; each next-symbol request while armed returns one
// symbol, data bits first (red, green, blue, MSB first, per pixel) and then
// the latch symbol with tlast set. The back end executes one queued item per
// clock, so the input side stalls only when the output register holds a symbol
// that is not taken and the two-entry queue has filled behind it. A request
// passes a queue slot, then the output register. The user writes the timing
// registers through the cfg port only while idle (unenforced); no reset sweep.
module led_strip_frame_encoder_core import lsfe_pkg::*; #(
	parameter int LED_COUNT = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // key_index, red, green, blue
	input  wire logic [1:0]  s_tuser,   // command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // first_level, first_ticks, second_ticks, pad
	output logic             m_tlast    // frame_end
);

	logic    q_ready;
	logic    push;
	entry_t  wr_entry;
	logic    pop;
	logic    q_valid;
	entry_t  rd_entry;
	cfg_wr_t cfg;

	assign cfg = '{we: cfg_we, index: cfg_index, data: cfg_data};

	lsfe_front #(.LED_COUNT(LED_COUNT)) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_ready  (q_ready),
		.push     (push),
		.entry    (wr_entry)
	);

	lsfe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.ready    (q_ready),
		.pop      (pop),
		.valid    (q_valid),
		.rd_entry (rd_entry)
	);

	lsfe_back #(.LED_COUNT(LED_COUNT)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_valid  (q_valid),
		.q_entry  (rd_entry),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

@@ hw/rtl/lsfe_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsfe_checker - port-level checks of the LED strip frame encoder
// Output hold under stall and symbol shape checks, bound to the top level.
// ----------------------------------------------------------------------------
module lsfe_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic        m_tlast
);

	// stalled symbol holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled symbol changed");

	a_latch_low: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> !m_tdata[0])
		else $error("latch symbol not driven low");

	a_data_high: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[0] && m_tdata[16:9] == 8'h00
			&& m_tdata[32:25] == 8'h00)
		else $error("data symbol malformed");

	a_latch_even: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[16:1] == m_tdata[32:17])
		else $error("latch halves differ");

endmodule

bind led_strip_frame_encoder_core lsfe_checker u_lsfe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
`default_nettype wire
